FILE: design/heap_budget_accounting_core_macros.svh
// Assertion macros for the heap budget accounting core.
// Included by the modules that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef HEAP_BUDGET_ACCOUNTING_CORE_MACROS_SVH
`define HEAP_BUDGET_ACCOUNTING_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define HBA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap budget accounting assertion failed");

// Next-cycle implication, checked outside reset.
`define HBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap budget accounting assertion failed");

`else

`define HBA_ASSERT_SAME(lbl, ante, cons)
`define HBA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: design/hba_pkg.sv
// Package for the heap budget accounting core: field widths, command,
// status and register codes, and charge constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hba_pkg;

    localparam int BYTE_W  = 48;
    localparam int COUNT_W = 32;
    localparam int CMD_W   = 2;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 3;
    localparam int PCT_W   = 7;
    localparam int ADDR_W  = 2;
    // Largest charge: 32 + (2^31 - 1) * 8 fits in 35 bits.
    localparam int COST_W  = 35;
    localparam int MARK_W  = BYTE_W + PCT_W;

    typedef logic [BYTE_W-1:0]  bytes_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [COST_W-1:0]  cost_t;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

    // Object kinds.
    localparam logic [KIND_W-1:0] KIND_INSTANCE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STRING   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PRIM_ARR = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OBJ_ARR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_HOST     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLASS    = 3'd5;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_LEN   = 3'd2;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_CMD   = 3'd4;

    // Configuration register indexes.
    localparam logic [ADDR_W-1:0] REG_BUDGET    = 2'd0;
    localparam logic [ADDR_W-1:0] REG_WATERMARK = 2'd1;
    localparam logic [ADDR_W-1:0] REG_EMERGENCY = 2'd2;

    // Charge constants.
    localparam cost_t HEADER_BYTES = 35'd32;
    localparam cost_t FLAT_BYTES   = 35'd48;
    localparam logic [PCT_W-1:0] PERCENT_FULL = 7'd100;
    localparam logic [15:0]      MAX_SLOTS    = 16'hFFFF;

endpackage

`default_nettype wire

FILE: design/hba_channels.sv
// Valid/ready channel interfaces of the heap budget accounting core:
// command request, result response and configuration write. Uses hba_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hba_req_if;
    logic                        valid;
    logic                        ready;
    logic [hba_pkg::CMD_W-1:0]   cmd;
    logic [hba_pkg::KIND_W-1:0]  object_kind;
    logic [hba_pkg::KIND_W-1:0]  element_kind;
    logic signed [31:0]          item_count;
    logic [hba_pkg::BYTE_W-1:0]  byte_amount;

    modport source (output valid, cmd, object_kind, element_kind, item_count,
                    byte_amount, input ready);
    modport sink   (input valid, cmd, object_kind, element_kind, item_count,
                    byte_amount, output ready);
endinterface

interface hba_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [hba_pkg::STAT_W-1:0]  status;
    logic [hba_pkg::BYTE_W-1:0]  bytes_charged;
    logic [hba_pkg::BYTE_W-1:0]  allocated_now;
    logic [hba_pkg::COUNT_W-1:0] object_count;
    logic                        collect_hint;

    modport source (output valid, status, bytes_charged, allocated_now, object_count,
                    collect_hint, input ready);
    modport sink   (input valid, status, bytes_charged, allocated_now, object_count,
                    collect_hint, output ready);
endinterface

interface hba_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [hba_pkg::ADDR_W-1:0]  addr;
    logic [hba_pkg::BYTE_W-1:0]  data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

FILE: design/heap_budget_accounting_core.sv
// Heap budget accounting core: charges allocations against a byte budget,
// books releases and answers watermark queries. Uses hba_pkg, hba_channels
// and heap_budget_accounting_core_macros.svh.
//
// Usage:
//   cfg  - register writes (0 heap_budget, 1 watermark_percent, 2 emergency_mode),
//          always ready; write only while no command is in flight.
//   req  - allocate, release or collection query; one beat per cycle unless rsp stalls.
//   rsp  - exactly one result beat per command, in command order.
// Each command passes an input register and a result register, in that order,
// and while rsp does not stall one command per cycle is sustained. The
// charged-byte and live-object counters are read and updated in the single
// stage between the two registers, which is what sets that rate.
// A register write applies to every command that reaches the datapath after it.
// When the receiver stalls, the result register holds and the input register
// still takes one more beat; req.ready then falls until rsp drains.
// Reset clears the configuration, both counters and all pending beats.
`timescale 1ns / 1ps
`default_nettype none

module heap_budget_accounting_core (
    input  wire     clk,
    input  wire     rst_n,
    hba_cfg_if.sink cfg,
    hba_req_if.sink req,
    hba_rsp_if.source rsp
);

`include "heap_budget_accounting_core_macros.svh"

    // Configuration.
    hba_pkg::bytes_t                 budget_reg;
    logic [hba_pkg::PCT_W-1:0]       wmark_reg;
    logic                            emerg_reg;
    logic [hba_pkg::PCT_W-1:0]       pct_sat;
    logic [hba_pkg::MARK_W-1:0]      mark100;

    // Input register.
    logic                            in_valid_reg;
    logic [hba_pkg::CMD_W-1:0]       cmd_reg;
    logic [hba_pkg::KIND_W-1:0]      okind_reg;
    logic [hba_pkg::KIND_W-1:0]      ekind_reg;
    logic [31:0]                     count_in_reg;
    hba_pkg::bytes_t                 amount_reg;

    // Accumulators.
    hba_pkg::bytes_t                 charged_reg;
    hba_pkg::bytes_t                 charged_next;
    hba_pkg::count_t                 objects_reg;
    hba_pkg::count_t                 objects_next;

    // Result register.
    logic                            out_valid_reg;
    logic [hba_pkg::STAT_W-1:0]      status_reg;
    logic [hba_pkg::STAT_W-1:0]      status_next;
    hba_pkg::bytes_t                 bcharged_reg;
    hba_pkg::bytes_t                 bcharged_next;
    logic                            hint_reg;
    logic                            hint_next;

    logic                            advance;
    logic                            req_take;

    // Datapath.
    logic                            negative;
    logic [30:0]                     len;
    hba_pkg::cost_t                  len_cost;
    hba_pkg::cost_t                  cost;
    logic [hba_pkg::BYTE_W:0]        alloc_sum;
    hba_pkg::bytes_t                 alloc_sat;
    logic [hba_pkg::BYTE_W:0]        query_sum;
    logic [hba_pkg::MARK_W:0]        query_x100;

    assign advance  = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req_take = req.valid && req.ready;

    assign req.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.bytes_charged = bcharged_reg;
    assign rsp.allocated_now = charged_reg;
    assign rsp.object_count  = objects_reg;
    assign rsp.collect_hint  = hint_reg;

    // Watermark comparison is done as 100 * (charged + request) > budget * percent,
    // which matches comparing against the truncated quotient.
    assign pct_sat = (wmark_reg > hba_pkg::PERCENT_FULL) ? hba_pkg::PERCENT_FULL : wmark_reg;
    assign mark100 = {{hba_pkg::PCT_W{1'b0}}, budget_reg} * {{hba_pkg::BYTE_W{1'b0}}, pct_sat};

    assign negative = count_in_reg[31];
    assign len      = count_in_reg[30:0];

    always_comb
    begin
        unique case (okind_reg)
            hba_pkg::KIND_INSTANCE: len_cost = {1'b0, len, 3'b000};
            hba_pkg::KIND_STRING:   len_cost = {3'b000, len, 1'b0};
            hba_pkg::KIND_PRIM_ARR: len_cost = {4'b0000, len} << ekind_reg[2:1];
            hba_pkg::KIND_OBJ_ARR:  len_cost = {2'b00, len, 2'b00};
            default:                len_cost = '0;
        endcase
        if (okind_reg == hba_pkg::KIND_HOST || okind_reg == hba_pkg::KIND_CLASS)
        begin
            cost = hba_pkg::FLAT_BYTES;
        end
        else
        begin
            cost = hba_pkg::HEADER_BYTES + len_cost;
        end
    end

    assign alloc_sum  = {1'b0, charged_reg} + {{(hba_pkg::BYTE_W + 1 - hba_pkg::COST_W){1'b0}}, cost};
    assign alloc_sat  = alloc_sum[hba_pkg::BYTE_W] ? '1 : alloc_sum[hba_pkg::BYTE_W-1:0];
    assign query_sum  = {1'b0, charged_reg} + {1'b0, amount_reg};
    assign query_x100 = ({{(hba_pkg::MARK_W - hba_pkg::BYTE_W){1'b0}}, query_sum} << 6)
                      + ({{(hba_pkg::MARK_W - hba_pkg::BYTE_W){1'b0}}, query_sum} << 5)
                      + ({{(hba_pkg::MARK_W - hba_pkg::BYTE_W){1'b0}}, query_sum} << 2);

    always_comb
    begin
        status_next   = hba_pkg::ST_OK;
        bcharged_next = '0;
        hint_next     = 1'b0;
        charged_next  = charged_reg;
        objects_next  = objects_reg;
        unique case (cmd_reg)
            hba_pkg::CMD_ALLOC:
            begin
                priority if (okind_reg > hba_pkg::KIND_CLASS)
                begin
                    status_next = hba_pkg::ST_BAD_CMD;
                end
                else if (okind_reg <= hba_pkg::KIND_OBJ_ARR && negative)
                begin
                    status_next = hba_pkg::ST_BAD_LEN;
                end
                else if (okind_reg == hba_pkg::KIND_INSTANCE && len[30:16] != '0)
                begin
                    status_next = hba_pkg::ST_BAD_LEN;
                end
                else if (!emerg_reg && alloc_sum > {1'b0, budget_reg})
                begin
                    status_next = hba_pkg::ST_EXHAUSTED;
                end
                else
                begin
                    charged_next  = alloc_sat;
                    objects_next  = (objects_reg != '1) ? objects_reg + 1'b1 : objects_reg;
                    bcharged_next = {{(hba_pkg::BYTE_W - hba_pkg::COST_W){1'b0}}, cost};
                end
            end
            hba_pkg::CMD_RELEASE:
            begin
                if (amount_reg > charged_reg)
                begin
                    charged_next = '0;
                    status_next  = hba_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    charged_next = charged_reg - amount_reg;
                end
                if (objects_reg == '0)
                begin
                    status_next = hba_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    objects_next = objects_reg - 1'b1;
                end
            end
            hba_pkg::CMD_QUERY:
            begin
                hint_next = (wmark_reg != '0) && (query_x100 > {1'b0, mark100});
            end
            default:
            begin
                status_next = hba_pkg::ST_BAD_CMD;
            end
        endcase
    end

    // Control state, configuration and accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg    <= '0;
            wmark_reg     <= '0;
            emerg_reg     <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            charged_reg   <= '0;
            objects_reg   <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.addr)
                    hba_pkg::REG_BUDGET:    budget_reg <= cfg.data;
                    hba_pkg::REG_WATERMARK: wmark_reg  <= cfg.data[hba_pkg::PCT_W-1:0];
                    hba_pkg::REG_EMERGENCY: emerg_reg  <= cfg.data[0];
                    default:                ;
                endcase
            end

            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                charged_reg   <= charged_next;
                objects_reg   <= objects_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            cmd_reg      <= req.cmd;
            okind_reg    <= req.object_kind;
            ekind_reg    <= req.element_kind;
            count_in_reg <= req.item_count;
            amount_reg   <= req.byte_amount;
        end
        if (advance)
        begin
            status_reg   <= status_next;
            bcharged_reg <= bcharged_next;
            hint_reg     <= hint_next;
        end
    end

    // A refused or non-allocating beat never reports a charge.
    `HBA_ASSERT_SAME(a_no_charge_on_error, rsp.valid && rsp.status != hba_pkg::ST_OK, rsp.bytes_charged == '0)
    // Only a successful query can raise the hint.
    `HBA_ASSERT_SAME(a_hint_ok_only, rsp.valid && rsp.collect_hint, rsp.status == hba_pkg::ST_OK)
    // The counters move only when a command leaves the input register.
    `HBA_ASSERT_NEXT(a_hold_counters, !advance, $stable(charged_reg) && $stable(objects_reg))
    // Every command that leaves the input register shows up as a result.
    `HBA_ASSERT_NEXT(a_result_follows, advance, out_valid_reg)

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for heap_budget_accounting_core: directed and random commands with
// a ledger that predicts every result beat. Depends on hba_pkg and hba_channels.
`timescale 1ns / 1ps

module tb_top;
    import hba_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_UNDEFINED  = 2'd3;
    localparam logic [KIND_W-1:0] KIND_BAD_FIRST = 3'd6;
    localparam logic [KIND_W-1:0] KIND_BAD_LAST  = 3'd7;
    localparam logic [KIND_W-1:0] ELEM_BOOL      = 3'd0;
    localparam logic [KIND_W-1:0] ELEM_LONG      = 3'd6;
    localparam logic [KIND_W-1:0] ELEM_DOUBLE    = 3'd7;
    localparam bit [63:0] SLOT_BYTES = 64'd8;
    localparam bit [63:0] UNIT_BYTES = 64'd2;
    localparam bit [63:0] REF_BYTES  = 64'd4;
    localparam bit [63:0] BYTE_MAX   = 64'hFFFF_FFFF_FFFF;
    localparam logic signed [31:0] LEN_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] LEN_MIN = 32'sh8000_0000;
    localparam int BURST_ALLOCS = 8;
    localparam int PHASE_ITEMS  = 185;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [KIND_W-1:0]  kind;
        logic [KIND_W-1:0]  elem;
        logic signed [31:0] count;
        bytes_t             amount;
    } heap_cmd_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        bytes_t            charge;
        bytes_t            total;
        count_t            live;
        logic              hint;
    } heap_result_t;

    // Tracks the budget registers and both counters, and holds the result beats still owed.
    class heap_ledger;
        bit [63:0]    budget;
        bit [63:0]    charged;
        bit [6:0]     watermark;
        bit           emergency;
        bit [31:0]    objects;
        heap_result_t owed_results[$];
        int           failures;
        int           reported;
        int           commands;
        int           writes;
        int           hints;
        int           status_seen[8];

        function void set_register(logic [ADDR_W-1:0] idx, bytes_t value);
            writes++;
            case (idx)
                REG_BUDGET:    budget = value;
                REG_WATERMARK: watermark = value[PCT_W-1:0];
                REG_EMERGENCY: emergency = value[0];
                default: ;
            endcase
        endfunction

        function void note_command(heap_cmd_t c);
            heap_result_t r;
            bit [63:0]    raw;
            bit [63:0]    amount;
            bit [63:0]    cost;
            bit [63:0]    pct;
            bit [63:0]    mark;
            raw      = {32'd0, c.count};
            amount   = {16'd0, c.amount};
            cost     = 0;
            r.status = ST_OK;
            r.charge = '0;
            r.hint   = 1'b0;
            commands++;
            case (c.cmd)
                CMD_ALLOC:
                begin
                    if (c.kind > KIND_CLASS)
                        r.status = ST_BAD_CMD;
                    else if (c.kind <= KIND_OBJ_ARR && c.count[31])
                        r.status = ST_BAD_LEN;
                    else if (c.kind == KIND_INSTANCE && raw > 64'(MAX_SLOTS))
                        r.status = ST_BAD_LEN;
                    else
                    begin
                        case (c.kind)
                            KIND_INSTANCE: cost = 64'(HEADER_BYTES) + raw * SLOT_BYTES;
                            KIND_STRING:   cost = 64'(HEADER_BYTES) + raw * UNIT_BYTES;
                            // Element widths come in pairs: 1, 1, 2, 2, 4, 4, 8, 8.
                            KIND_PRIM_ARR: cost = 64'(HEADER_BYTES) + (raw << c.elem[2:1]);
                            KIND_OBJ_ARR:  cost = 64'(HEADER_BYTES) + raw * REF_BYTES;
                            default:       cost = 64'(FLAT_BYTES);
                        endcase
                        if (!emergency && charged + cost > budget)
                            r.status = ST_EXHAUSTED;
                        else
                        begin
                            charged = (charged + cost > BYTE_MAX) ? BYTE_MAX : charged + cost;
                            if (objects != 32'hFFFF_FFFF)
                                objects++;
                            r.charge = cost[BYTE_W-1:0];
                        end
                    end
                end
                CMD_RELEASE:
                begin
                    // The sweep still books what it can when it runs past zero.
                    if (amount > charged)
                    begin
                        charged  = 0;
                        r.status = ST_UNDERFLOW;
                    end
                    else
                        charged = charged - amount;
                    if (objects == 0)
                        r.status = ST_UNDERFLOW;
                    else
                        objects--;
                end
                CMD_QUERY:
                begin
                    pct = (watermark > PERCENT_FULL) ? 64'(PERCENT_FULL) : 64'(watermark);
                    if (pct != 0)
                    begin
                        mark   = (budget * pct) / 64'(PERCENT_FULL);
                        r.hint = (amount > mark) || (charged > mark - amount);
                    end
                end
                default: r.status = ST_BAD_CMD;
            endcase
            r.total = charged[BYTE_W-1:0];
            r.live  = objects;
            owed_results.insert(owed_results.size(), r);
        endfunction

        function void check_result(heap_result_t got);
            heap_result_t want;
            bit           bad;
            if (owed_results.size() == 0)
            begin
                failures++;
                if (reported < 40)
                begin
                    reported++;
                    $display("%0t: result beat with none expected, status %0d",
                             $time, got.status);
                end
                return;
            end
            want = owed_results.pop_front();
            status_seen[want.status]++;
            if (want.hint)
                hints++;
            bad = (got.status !== want.status) || (got.charge !== want.charge) ||
                  (got.total !== want.total) || (got.live !== want.live) ||
                  (got.hint !== want.hint);
            if (!bad)
                return;
            failures++;
            // Past the first few dozen bad beats only the count is kept.
            if (reported >= 40)
                return;
            reported++;
            if (got.status !== want.status)
                $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            if (got.charge !== want.charge)
                $display("%0t: bytes_charged expected %0h, got %0h",
                         $time, want.charge, got.charge);
            if (got.total !== want.total)
                $display("%0t: allocated_now expected %0h, got %0h",
                         $time, want.total, got.total);
            if (got.live !== want.live)
                $display("%0t: object count expected %0h, got %0h", $time, want.live, got.live);
            if (got.hint !== want.hint)
                $display("%0t: collect_hint expected %0b, got %0b", $time, want.hint, got.hint);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    bit         steady;
    heap_ledger ledger;

    hba_cfg_if cfg_ch ();
    hba_req_if req_ch ();
    hba_rsp_if rsp_ch ();

    heap_budget_accounting_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: random stalls, mostly short, now and then long, none while steady.
    initial
    begin
        int stall_left;
        int r;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (!steady && r < 15)
                    stall_left = $urandom_range(1, 3);
                else if (!steady && r < 17)
                    stall_left = $urandom_range(15, 50);
            end
        end
    end

    always @(posedge clk)
    begin
        heap_result_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status = rsp_ch.status;
            got.charge = rsp_ch.bytes_charged;
            got.total  = rsp_ch.allocated_now;
            got.live   = rsp_ch.object_count;
            got.hint   = rsp_ch.collect_hint;
            ledger.check_result(got);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic drive_command(heap_cmd_t c);
        int r;
        int gap;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (!steady)
        begin
            if (r >= 97)
                gap = $urandom_range(15, 50);
            else if (r >= 70)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= c.cmd;
        req_ch.object_kind  <= c.kind;
        req_ch.element_kind <= c.elem;
        req_ch.item_count   <= c.count;
        req_ch.byte_amount  <= c.amount;
        do @(posedge clk); while (!req_ch.ready);
        ledger.note_command(c);
        @(negedge clk);
    endtask

    task automatic issue(logic [CMD_W-1:0] cmd, logic [KIND_W-1:0] kind,
                         logic [KIND_W-1:0] elem, logic signed [31:0] count, bytes_t amount);
        heap_cmd_t c;
        c.cmd    = cmd;
        c.kind   = kind;
        c.elem   = elem;
        c.count  = count;
        c.amount = amount;
        drive_command(c);
    endtask

    // Holds the sender until every owed result is back, then lets the pipeline settle.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (ledger.owed_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_settings(bytes_t budget, logic [PCT_W-1:0] pct, bit emergency);
        logic [ADDR_W-1:0] idx[3];
        bytes_t            vals[3];
        idx  = '{REG_BUDGET, REG_WATERMARK, REG_EMERGENCY};
        vals = '{budget, bytes_t'(pct), bytes_t'(emergency)};
        for (int i = 0; i < 3; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.addr  <= idx[i];
            cfg_ch.data  <= vals[i];
            do @(posedge clk); while (!cfg_ch.ready);
            ledger.set_register(idx[i], vals[i]);
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
        // The sender stays quiet between the writes and the next command.
        repeat (3) @(negedge clk);
    endtask

    task automatic run_random_phase(int n);
        heap_cmd_t c;
        int        r;
        int        s;
        int        t;
        for (int i = 0; i < n; i++)
        begin
            steady   = (i < 30);
            c.cmd    = CMD_ALLOC;
            c.kind   = KIND_W'($urandom_range(0, 5));
            c.elem   = KIND_W'($urandom_range(0, 7));
            c.count  = $urandom;
            c.amount = bytes_t'({$urandom, $urandom});
            r = $urandom_range(0, 99);
            s = $urandom_range(0, 99);
            t = $urandom_range(0, 99);
            if (r < 55)
            begin
                if (s < 5)
                    c.kind = KIND_W'($urandom_range(KIND_BAD_FIRST, KIND_BAD_LAST));
                if (t < 65)
                    c.count = $urandom_range(0, 64);
                else if (t < 78)
                    c.count = $urandom_range(65, 70000);
                else if (t < 85)
                    c.count = $urandom_range(70001, LEN_MAX);
                else if (t < 93)
                    c.count[31] = 1'b1;
            end
            else if (r < 80)
            begin
                c.cmd = CMD_RELEASE;
                if (s < 40)
                    c.amount = bytes_t'($urandom_range(0, 512));
                else if (s < 55)
                    c.amount = ledger.charged[BYTE_W-1:0];
                else if (s < 75)
                    c.amount = bytes_t'({$urandom, $urandom} % (ledger.charged + 1));
            end
            else if (r < 95)
            begin
                c.cmd = CMD_QUERY;
                if (s < 40)
                    c.amount = bytes_t'({$urandom, $urandom} % (ledger.budget + 1));
                else if (s < 70)
                    c.amount = bytes_t'($urandom_range(0, 4096));
            end
            else
                c.cmd = CMD_UNDEFINED;
            drive_command(c);
            if ($urandom_range(0, 99) == 0)
                wait_idle();
        end
        steady = 1'b0;
    endtask

    initial
    begin
        ledger               = new();
        steady               = 1'b0;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.cmd           = CMD_ALLOC;
        req_ch.object_kind   = KIND_INSTANCE;
        req_ch.element_kind  = ELEM_BOOL;
        req_ch.item_count    = '0;
        req_ch.byte_amount   = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.addr          = REG_BUDGET;
        cfg_ch.data          = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: a 4 KiB budget with the watermark at half of it.
        write_settings(48'd4096, 7'd50, 1'b0);
        issue(CMD_RELEASE, KIND_INSTANCE, ELEM_BOOL, 0, 48'd0);
        issue(CMD_QUERY, KIND_INSTANCE, ELEM_BOOL, 0, 48'd0);
        issue(CMD_ALLOC, KIND_INSTANCE, ELEM_BOOL, 0, 48'd0);
        issue(CMD_ALLOC, KIND_INSTANCE, ELEM_BOOL, 65535, 48'd0);
        issue(CMD_ALLOC, KIND_INSTANCE, ELEM_BOOL, 65536, 48'd0);
        issue(CMD_ALLOC, KIND_INSTANCE, ELEM_BOOL, -1, 48'd0);
        issue(CMD_ALLOC, KIND_STRING, ELEM_BOOL, LEN_MIN, 48'd0);
        issue(CMD_ALLOC, KIND_PRIM_ARR, ELEM_BOOL, -5, 48'd0);
        issue(CMD_ALLOC, KIND_OBJ_ARR, ELEM_BOOL, -1, 48'd0);
        issue(CMD_ALLOC, KIND_STRING, ELEM_BOOL, 100, 48'd0);
        issue(CMD_ALLOC, KIND_PRIM_ARR, ELEM_BOOL, 10, 48'd0);
        issue(CMD_ALLOC, KIND_PRIM_ARR, ELEM_DOUBLE, 10, 48'd0);
        issue(CMD_ALLOC, KIND_OBJ_ARR, ELEM_BOOL, 50, 48'd0);
        issue(CMD_ALLOC, KIND_OBJ_ARR, ELEM_BOOL, LEN_MAX, 48'd0);
        issue(CMD_ALLOC, KIND_HOST, ELEM_BOOL, -1, 48'd0);
        issue(CMD_ALLOC, KIND_CLASS, ELEM_DOUBLE, LEN_MAX, 48'd0);
        issue(CMD_ALLOC, KIND_BAD_FIRST, ELEM_BOOL, 1, 48'd0);
        issue(CMD_ALLOC, KIND_BAD_LAST, ELEM_BOOL, 1, 48'd0);
        issue(CMD_UNDEFINED, KIND_INSTANCE, ELEM_BOOL, 1, 48'd1);
        issue(CMD_QUERY, KIND_INSTANCE, ELEM_BOOL, 0, 48'd2048);
        issue(CMD_QUERY, KIND_INSTANCE, ELEM_BOOL, 0, 48'hFFFF_FFFF_FFFF);
        issue(CMD_RELEASE, KIND_INSTANCE, ELEM_BOOL, 0, 48'd48);
        issue(CMD_RELEASE, KIND_INSTANCE, ELEM_BOOL, 0, 48'hFFFF_FFFF_FFFF);

        // Random phases, each under its own register settings.
        wait_idle();
        write_settings(48'd0, 7'd0, 1'b0);
        run_random_phase(PHASE_ITEMS);
        wait_idle();
        write_settings(48'hFFFF_FFFF_FFFF, PERCENT_FULL, 1'b0);
        run_random_phase(PHASE_ITEMS);
        wait_idle();
        write_settings(bytes_t'($urandom_range(1000, 100000)), 7'd127, 1'b1);
        run_random_phase(PHASE_ITEMS);
        wait_idle();
        write_settings(bytes_t'($urandom_range(2000, 400000)), PCT_W'($urandom_range(1, 99)),
                       1'b0);
        run_random_phase(PHASE_ITEMS);
        wait_idle();
        write_settings(bytes_t'({$urandom, $urandom}), PCT_W'($urandom_range(0, 127)),
                       1'($urandom_range(0, 1)));
        run_random_phase(PHASE_ITEMS);

        // Under the emergency override the largest long arrays run far past the budget.
        wait_idle();
        write_settings(48'd8192, PERCENT_FULL, 1'b1);
        steady = 1'b1;
        for (int i = 0; i < BURST_ALLOCS; i++)
            issue(CMD_ALLOC, KIND_PRIM_ARR, ELEM_LONG, LEN_MAX, 48'd0);
        steady = 1'b0;
        wait_idle();
        write_settings(48'd8192, PERCENT_FULL, 1'b0);
        issue(CMD_ALLOC, KIND_HOST, ELEM_BOOL, 0, 48'd0);
        issue(CMD_QUERY, KIND_INSTANCE, ELEM_BOOL, 0, 48'd0);
        issue(CMD_RELEASE, KIND_INSTANCE, ELEM_BOOL, 0, 48'hFFFF_FFFF_FFFF);
        issue(CMD_RELEASE, KIND_INSTANCE, ELEM_BOOL, 0, 48'd1);

        wait_idle();
        repeat (10) @(posedge clk);
        $display("Ran %0d commands across %0d register writes, %0d hints raised, %0d %s",
                 ledger.commands, ledger.writes, ledger.hints, BURST_ALLOCS,
                 "oversized allocations under the override.");
        $display("Statuses seen: %0d ok, %0d over budget, %0d bad length, %0d underflow, %0d %s",
                 ledger.status_seen[ST_OK], ledger.status_seen[ST_EXHAUSTED],
                 ledger.status_seen[ST_BAD_LEN], ledger.status_seen[ST_UNDERFLOW],
                 ledger.status_seen[ST_BAD_CMD], "bad command.");
        if (ledger.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #(15_000_000);
        $display("Timed out with %0d results still owed.", ledger.owed_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: heap_budget_accounting_core.f
+incdir+design
design/hba_pkg.sv
design/hba_channels.sv
design/heap_budget_accounting_core.sv
sim/tb_top.sv
